FILE: design/wfpa_pkg.sv
// wfpa_pkg: shared types and constants for the worst-fit partition allocator.
// Used by wfpa_cell and worst_fit_partition_allocator; depends on nothing.

package wfpa_pkg;

    localparam int CNT_W        = 6;   // block_count register width
    localparam int IDX_FIELD_W  = 5;   // block_index / chosen_block field width
    localparam int SIZE_FIELD_W = 16;  // size / chosen_size / leftover field width

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 6'd32;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_FIELD_W-1:0]  block_index;
        logic [SIZE_FIELD_W-1:0] size;
    } in_item_t;

    typedef struct packed {
        logic                    granted;
        logic [IDX_FIELD_W-1:0]  chosen_block;
        logic [SIZE_FIELD_W-1:0] chosen_size;
        logic [SIZE_FIELD_W-1:0] leftover;
    } out_item_t;

    // control half of the search record that walks down the cell chain
    typedef struct packed {
        logic valid;
        logic found;
    } srch_ctl_t;

endpackage

FILE: design/wfpa_cell.sv
// wfpa_cell: one partition of the allocator (size and taken flag) plus one
// stage of the worst-fit search chain. Depends on wfpa_pkg.

module wfpa_cell
    import wfpa_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IDX_W     = 5,
    parameter int SIZE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // partition maintenance
    input  logic                 load_en,
    input  logic [IDX_W-1:0]     load_idx,
    input  logic [SIZE_BITS-1:0] load_size,
    input  logic                 take_en,
    input  logic [IDX_W-1:0]     take_idx,
    // search broadcast
    input  logic [CNT_W-1:0]     block_count,
    input  logic [SIZE_BITS-1:0] req,
    // search record from the previous cell
    input  srch_ctl_t            ctl_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [SIZE_BITS-1:0] left_in,
    input  logic [SIZE_BITS-1:0] size_in,
    // search record to the next cell
    output srch_ctl_t            ctl_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [SIZE_BITS-1:0] left_out,
    output logic [SIZE_BITS-1:0] size_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX % 64);
    localparam bit               CNT_OK = (IDX < 64);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 taken_reg;
    srch_ctl_t            ctl_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] bsize_reg;

    logic                 in_range;
    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 pick;

    assign in_range = CNT_OK && (block_count > MY_CNT);
    assign fits     = in_range && !taken_reg && (size_reg >= req);
    assign left     = size_reg - req;
    assign pick     = ctl_in.valid && fits && (!ctl_in.found || (left > left_in));

    // partition storage
    always_ff @(posedge clk)
    begin
        if (load_en && (load_idx == MY_IDX))
        begin
            size_reg <= load_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else if (load_en && (load_idx == MY_IDX))
        begin
            taken_reg <= 1'b0;
        end
        else if (take_en && (take_idx == MY_IDX))
        begin
            taken_reg <= 1'b1;
        end
    end

    // search stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= ctl_in.valid;
            ctl_reg.found <= ctl_in.found || pick;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= pick ? MY_IDX   : idx_in;
        left_reg  <= pick ? left     : left_in;
        bsize_reg <= pick ? size_reg : size_in;
    end

    assign ctl_out  = ctl_reg;
    assign idx_out  = idx_reg;
    assign left_out = left_reg;
    assign size_out = bsize_reg;

endmodule

FILE: design/worst_fit_partition_allocator.sv
// worst_fit_partition_allocator: top level, command decode, result buffering
// and the chain of wfpa_cell partitions. Depends on wfpa_pkg and wfpa_cell.

// A fixed-partition worst-fit allocator. Each of BLOCKS partitions lives in a
// cell of its own, holding its size and a taken flag. A load beat (cmd 0)
// writes one partition's size and frees it; it returns no beat. An allocate
// beat (cmd 1) sends a search record down the cell chain, one cell per
// cycle; each cell whose index is below block_count and that is free and
// large enough replaces the record if it leaves a strictly larger leftover,
// so ties keep the lowest index. The record is launched from start_reg,
// walks through the BLOCKS cells, is captured from the tail into a pending
// register and is then loaded into the output register once that is free,
// where out_valid rises; the next item is accepted only after that hand-off,
// and no new item is accepted during the walk. The winner is marked taken as
// the record leaves the last cell. A request that fits nowhere returns a beat
// with granted low and all other fields zero. A finished result sits in an
// output register, so the next item is accepted while it waits to be taken.
// block_count (reset 32) is written through the cfg channel, which is always
// ready; write it only while the block is idle.

module worst_fit_partition_allocator
    import wfpa_pkg::*;
#(
    parameter int BLOCKS    = 32,
    parameter int SIZE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    // command channel
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     block_count_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 start_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    out_item_t            pend_reg;

    // search chain: element k feeds cell k, element BLOCKS is the tail
    srch_ctl_t            ctl_chain  [BLOCKS+1];
    logic [IDX_W-1:0]     idx_chain  [BLOCKS+1];
    logic [SIZE_BITS-1:0] left_chain [BLOCKS+1];
    logic [SIZE_BITS-1:0] size_chain [BLOCKS+1];

    logic                 in_fire;
    logic                 load_en;
    logic                 alloc_fire;
    logic [IDX_W-1:0]     load_idx;
    logic [SIZE_BITS-1:0] load_size;
    logic                 take_en;
    logic                 tail_valid;
    logic                 out_free;

    // configuration: always accept the write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            block_count_reg <= cfg_data;
        end
    end

    // command decode; loads beyond the partition range are dropped
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign alloc_fire = in_fire && (in_data.cmd == CMD_ALLOC);
    assign load_en    = in_fire && (in_data.cmd == CMD_LOAD)
                        && (int'(in_data.block_index) < BLOCKS);
    assign load_idx   = IDX_W'(in_data.block_index);
    assign load_size  = SIZE_BITS'(in_data.size);

    // head of the chain: a fresh, empty search record
    assign ctl_chain[0].valid = start_reg;
    assign ctl_chain[0].found = 1'b0;
    assign idx_chain[0]       = '0;
    assign left_chain[0]      = '0;
    assign size_chain[0]      = '0;

    // tail of the chain: mark the winner taken as the record leaves
    assign tail_valid = ctl_chain[BLOCKS].valid;
    assign take_en    = tail_valid && ctl_chain[BLOCKS].found;

    for (genvar k = 0; k < BLOCKS; k++)
    begin : g_cell
        wfpa_cell #(
            .IDX       (k),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load_en     (load_en),
            .load_idx    (load_idx),
            .load_size   (load_size),
            .take_en     (take_en),
            .take_idx    (idx_chain[BLOCKS]),
            .block_count (block_count_reg),
            .req         (req_reg),
            .ctl_in      (ctl_chain[k]),
            .idx_in      (idx_chain[k]),
            .left_in     (left_chain[k]),
            .size_in     (size_chain[k]),
            .ctl_out     (ctl_chain[k+1]),
            .idx_out     (idx_chain[k+1]),
            .left_out    (left_chain[k+1]),
            .size_out    (size_chain[k+1])
        );
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer: launch the walk, catch the tail, hand off to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= alloc_fire;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (alloc_fire)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (tail_valid)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (alloc_fire)
        begin
            req_reg <= SIZE_BITS'(in_data.size);
        end
        if ((state_reg == ST_SCAN) && tail_valid)
        begin
            pend_reg.granted      <= ctl_chain[BLOCKS].found;
            pend_reg.chosen_block <= IDX_FIELD_W'(idx_chain[BLOCKS]);
            pend_reg.chosen_size  <= SIZE_FIELD_W'(size_chain[BLOCKS]);
            pend_reg.leftover     <= SIZE_FIELD_W'(left_chain[BLOCKS]);
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
